// ===== rtl/core/jpdtl_pkg.sv =====
package jpdtl_pkg;

    // Number of joints served, and the width of a joint index.
    localparam int JOINTS = 7;
    localparam int JW     = 3;

    // Quotient bits formed by the scaling divider.
    localparam int QBITS = 16;

    // Configuration register indexes.
    localparam logic [2:0] REG_KP_LO  = 3'd0;
    localparam logic [2:0] REG_KP_HI  = 3'd1;
    localparam logic [2:0] REG_KD_LO  = 3'd2;
    localparam logic [2:0] REG_KD_HI  = 3'd3;
    localparam logic [2:0] REG_LIM_LO = 3'd4;
    localparam logic [2:0] REG_LIM_HI = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MULP,
        S_MULD,
        S_ADD,
        S_SRD,
        S_SMUL,
        S_SUPD,
        S_ERD,
        S_EMUL,
        S_DIV,
        S_SET,
        S_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MULP,
        OP_MULD,
        OP_ADD,
        OP_SRD,
        OP_SMUL,
        OP_SUPD,
        OP_ERD,
        OP_EMUL,
        OP_DIV,
        OP_SET
    } op_t;

    typedef struct packed {
        op_t           op;
        logic [JW-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic scaled;
    } status_t;

    // Select the 16-bit lane of joint j from a low/high register pair.
    function automatic logic [15:0] lane16(input logic [63:0] lo, input logic [63:0] hi,
                                           input logic [JW-1:0] j);
        logic [63:0] w;
        w = j[2] ? hi : lo;
        return w[16*j[1:0] +: 16];
    endfunction

endpackage

// ===== rtl/core/jpdtl_ctrl.sv =====
module jpdtl_ctrl
    import jpdtl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t        state_reg, state_next;
    logic [JW-1:0] idx_reg, idx_next;
    logic [3:0]    step_reg, step_next;

    // State and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_MULP;
            end
            S_MULP: state_next = S_MULD;
            S_MULD: state_next = S_ADD;
            S_ADD:
            begin
                idx_next   = '0;
                state_next = status.last ? S_SRD : S_IDLE;
            end
            S_SRD:  state_next = S_SMUL;
            S_SMUL: state_next = S_SUPD;
            S_SUPD:
            begin
                if (idx_reg == JW'(JOINTS - 1))
                begin
                    idx_next   = '0;
                    state_next = S_ERD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SRD;
                end
            end
            S_ERD:  state_next = status.scaled ? S_EMUL : S_SET;
            S_EMUL:
            begin
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == 4'(QBITS - 1))
                    state_next = S_SET;
            end
            S_SET:  state_next = S_OUT;
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (idx_reg == JW'(JOINTS - 1))
                    begin
                        idx_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_ERD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        out_valid = (state_reg == S_OUT);
        cmd.idx   = idx_reg;
        unique case (state_reg)
            S_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
            S_MULP:  cmd.op = OP_MULP;
            S_MULD:  cmd.op = OP_MULD;
            S_ADD:   cmd.op = OP_ADD;
            S_SRD:   cmd.op = OP_SRD;
            S_SMUL:  cmd.op = OP_SMUL;
            S_SUPD:  cmd.op = OP_SUPD;
            S_ERD:   cmd.op = OP_ERD;
            S_EMUL:  cmd.op = OP_EMUL;
            S_DIV:   cmd.op = OP_DIV;
            S_SET:   cmd.op = OP_SET;
            S_OUT:   cmd.op = OP_NONE;
            default: cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== rtl/core/jpdtl_datapath.sv =====
module jpdtl_datapath
    import jpdtl_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [63:0]   cfg_data,
    input  logic [JW-1:0] in_joint,
    input  logic [95:0]   in_data,
    input  logic          in_last,
    input  cmd_t          cmd,
    output status_t       status,
    output logic [JW-1:0] out_joint,
    output logic [15:0]   drive_torque,
    output logic          was_scaled,
    output logic          last_out
);

    logic [63:0] kp_lo_reg, kp_hi_reg, kd_lo_reg, kd_hi_reg;
    logic [62:0] lim_lo_reg, lim_hi_reg;

    logic [JW-1:0]      joint_reg;
    logic signed [15:0] rp_reg, mp_reg, rv_reg, mv_reg, ff_reg, gr_reg;
    logic               last_reg;

    logic signed [33:0] prod_reg;
    logic signed [27:0] pterm_reg;
    logic [31:0]        store [JOINTS];
    logic [31:0]        rd_reg;
    logic [46:0]        pa_reg, pb_reg;
    logic               worst_valid_reg;
    logic [14:0]        best_lim_reg;
    logic [31:0]        best_mag_reg;
    logic [31:0]        rem_reg;
    logic [QBITS-1:0]   quot_reg;

    logic signed [16:0] mul_a, mul_b;
    logic signed [16:0] pos_err, vel_err;
    logic signed [31:0] torque;
    logic [31:0]        mag;
    logic [15:0]        lim_lane;
    logic [14:0]        lim;
    logic [46:0]        sprod;
    logic [32:0]        trial;
    logic               ge;
    logic [15:0]        qsigned;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_lo_reg  <= '0;
            kp_hi_reg  <= '0;
            kd_lo_reg  <= '0;
            kd_hi_reg  <= '0;
            lim_lo_reg <= '0;
            lim_hi_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KP_LO:  kp_lo_reg  <= cfg_data;
                REG_KP_HI:  kp_hi_reg  <= cfg_data;
                REG_KD_LO:  kd_lo_reg  <= cfg_data;
                REG_KD_HI:  kd_hi_reg  <= cfg_data;
                REG_LIM_LO: lim_lo_reg <= cfg_data[62:0];
                REG_LIM_HI: lim_hi_reg <= cfg_data[62:0];
                default:    ;
            endcase
        end
    end

    // Errors and the shared gain multiplier operands.
    assign pos_err = 17'(rp_reg) - 17'(mp_reg);
    assign vel_err = 17'(rv_reg) - 17'(mv_reg);
    always_comb
    begin
        if (cmd.op == OP_MULP)
        begin
            mul_a = $signed({1'b0, lane16(kp_lo_reg, kp_hi_reg, joint_reg)});
            mul_b = pos_err;
        end
        else
        begin
            mul_a = $signed({1'b0, lane16(kd_lo_reg, kd_hi_reg, joint_reg)});
            mul_b = vel_err;
        end
    end

    // Torque sum; the velocity term is the registered product shifted by 12.
    assign torque = 32'(ff_reg) - 32'(gr_reg) + 32'(pterm_reg)
                  + 32'($signed(prod_reg[33:12]));

    // Magnitude of the torque read from the store, and the limit of the current joint.
    assign mag = rd_reg[31] ? (~rd_reg + 32'd1) : rd_reg;
    assign lim_lane = lane16({1'b0, lim_lo_reg}, {1'b0, lim_hi_reg}, cmd.idx);
    assign lim = lim_lane[14:0];
    assign sprod = 47'(mag) * 47'(best_lim_reg);

    // One restoring division step.
    assign trial = {rem_reg, quot_reg[QBITS-1]};
    assign ge    = (trial >= {1'b0, best_mag_reg});
    assign qsigned = rd_reg[31] ? (16'd0 - quot_reg) : quot_reg;

    assign status.last   = last_reg;
    assign status.scaled = worst_valid_reg && (32'(best_lim_reg) < best_mag_reg);

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg        <= 1'b0;
            worst_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_LOAD)
                last_reg <= in_last;
            if (cmd.op == OP_SRD && cmd.idx == '0)
                worst_valid_reg <= 1'b0;
            else if (cmd.op == OP_SUPD && mag != '0 && (!worst_valid_reg || pa_reg < pb_reg))
                worst_valid_reg <= 1'b1;
        end
    end

    // Torque store; slots hold nothing defined until written.
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_ADD && int'(joint_reg) < JOINTS)
            store[joint_reg] <= torque;
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                joint_reg <= in_joint;
                rp_reg    <= in_data[15:0];
                mp_reg    <= in_data[31:16];
                rv_reg    <= in_data[47:32];
                mv_reg    <= in_data[63:48];
                ff_reg    <= in_data[79:64];
                gr_reg    <= in_data[95:80];
            end
            OP_MULP:
            begin
                prod_reg <= 34'(mul_a) * 34'(mul_b);
            end
            OP_MULD:
            begin
                pterm_reg <= prod_reg[33:6];
                prod_reg  <= 34'(mul_a) * 34'(mul_b);
            end
            OP_SRD, OP_ERD:
            begin
                rd_reg <= store[cmd.idx];
            end
            OP_SMUL:
            begin
                pa_reg <= 47'(lim) * 47'(best_mag_reg);
                pb_reg <= 47'(best_lim_reg) * 47'(mag);
            end
            OP_SUPD:
            begin
                if (mag != '0 && (!worst_valid_reg || pa_reg < pb_reg))
                begin
                    best_lim_reg <= lim;
                    best_mag_reg <= mag;
                end
            end
            OP_EMUL:
            begin
                rem_reg  <= 32'(sprod[46:QBITS]);
                quot_reg <= sprod[QBITS-1:0];
            end
            OP_DIV:
            begin
                rem_reg  <= ge ? 32'(trial - {1'b0, best_mag_reg}) : trial[31:0];
                quot_reg <= {quot_reg[QBITS-2:0], ge};
            end
            OP_SET:
            begin
                out_joint    <= cmd.idx;
                drive_torque <= status.scaled ? qsigned : rd_reg[15:0];
                was_scaled   <= status.scaled;
                last_out     <= (cmd.idx == JW'(JOINTS - 1));
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/joint_pd_feedforward_torque_limiter.sv =====
// Joint PD controller with feedforward and torque-vector saturation. Each joint transaction
// on the slave side makes two passes through one shared 17x17 gain multiplier and a 32-bit
// sum and is not answered. A transaction with tlast set closes the control period: a
// search over the 7 stored torques, comparing a pair of limit cross products per joint,
// finds the joint with the smallest limit/|t| ratio, then one result per joint is sent in
// ascending order, unscaled, or when the vector is scaled, through the scaling product and
// the 16-step bit-serial divider; each result waits for the master side to take it.
// A stored torque slot that was never written since reset gives an undefined result.
module joint_pd_feedforward_torque_limiter
    import jpdtl_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [63:0]   cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // ref_position, meas_position, ref_velocity, meas_velocity, feedforward_torque,
    // gravity_torque
    input  logic [95:0]   s_axis_tdata,
    // joint
    input  logic [2:0]    s_axis_tuser,
    input  logic          s_axis_tlast,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // drive_torque
    output logic [15:0]   m_axis_tdata,
    // out_joint, was_scaled
    output logic [3:0]    m_axis_tuser,
    output logic          m_axis_tlast
);

    cmd_t          cmd;
    status_t       status;
    logic [JW-1:0] out_joint;
    logic          was_scaled;

    // Sequencer.
    jpdtl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic, store and result registers.
    jpdtl_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_joint     (s_axis_tuser),
        .in_data      (s_axis_tdata),
        .in_last      (s_axis_tlast),
        .cmd          (cmd),
        .status       (status),
        .out_joint    (out_joint),
        .drive_torque (m_axis_tdata),
        .was_scaled   (was_scaled),
        .last_out     (m_axis_tlast)
    );

    assign m_axis_tuser = {was_scaled, out_joint};

    // The block never takes input while a result is offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input accepted while a result is pending");

    // An accepted transaction starts work, so the next cycle takes nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transaction");

    // The result marked last belongs to the highest joint.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[2:0] == 3'(JOINTS - 1))
        else $error("last result on the wrong joint");

endmodule

// ===== tb/sv/tb_joint_pd_feedforward_torque_limiter.sv =====
`timescale 1ns / 100ps

module tb_joint_pd_feedforward_torque_limiter;
    import jpdtl_pkg::*;

    // One joint sample on the slave side.
    typedef struct {
        logic [2:0]         joint;
        logic signed [15:0] ref_pos;
        logic signed [15:0] meas_pos;
        logic signed [15:0] ref_vel;
        logic signed [15:0] meas_vel;
        logic signed [15:0] ff_torque;
        logic signed [15:0] grav_torque;
        logic               last_joint;
    } joint_sample_t;

    // One commanded torque on the master side.
    typedef struct {
        logic [2:0]         joint;
        logic signed [15:0] torque;
        logic               scaled;
        logic               last;
    } drive_cmd_t;

    localparam int SETTLE_CYCLES = 200;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;

    logic          clk;
    logic          rst_n;
    logic          cfg_we;
    logic [2:0]    cfg_index;
    logic [63:0]   cfg_data;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    // ref_position, meas_position, ref_velocity, meas_velocity, feedforward_torque,
    // gravity_torque
    logic [95:0]   s_axis_tdata;
    // joint
    logic [2:0]    s_axis_tuser;
    logic          s_axis_tlast;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    // drive_torque
    logic [15:0]   m_axis_tdata;
    // out_joint, was_scaled
    logic [3:0]    m_axis_tuser;
    logic          m_axis_tlast;

    joint_sample_t      sample_queue[$];
    drive_cmd_t         torque_queue[$];
    joint_sample_t      offered;
    logic [63:0]        reg_shadow[6];
    logic signed [31:0] torque_store[8];
    logic               steady;
    logic               hold_request;
    int                 hold_count;
    int                 mismatches;
    int                 idle_cycles;
    int                 periods_closed;
    int                 periods_scaled;
    int                 results_seen;

    joint_pd_feedforward_torque_limiter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock generation.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Pick the 16-bit lane of joint j from a low/high register pair.
    function automatic longint gain_lane(input int base, input int j);
        logic [63:0] w;
        w = (j < 4) ? reg_shadow[base] : reg_shadow[base + 1];
        return longint'(w[16 * (j % 4) +: 16]);
    endfunction

    // Update the torque store for one sample and, on a closing sample,
    // queue the saturated torque vector.
    task automatic predict_torques(input joint_sample_t s);
        longint     pos_err;
        longint     vel_err;
        longint     sum;
        longint     mag;
        longint     lim;
        longint     worst_lim;
        longint     worst_mag;
        longint     quot;
        logic       found;
        logic       scale;
        drive_cmd_t cmd;
        pos_err = longint'(s.ref_pos) - longint'(s.meas_pos);
        vel_err = longint'(s.ref_vel) - longint'(s.meas_vel);
        if (s.joint < JOINTS)
        begin
            sum = longint'(s.ff_torque) - longint'(s.grav_torque)
                + ((gain_lane(REG_KP_LO, s.joint) * pos_err) >>> 6)
                + ((gain_lane(REG_KD_LO, s.joint) * vel_err) >>> 12);
            torque_store[s.joint] = sum[31:0];
        end
        if (s.last_joint)
        begin
            found = 1'b0;
            worst_lim = 0;
            worst_mag = 0;
            // Smallest limit/|t| ratio wins; zero torques never limit.
            for (int i = 0; i < JOINTS; i++)
            begin
                mag = longint'(torque_store[i]);
                if (mag < 0)
                    mag = -mag;
                lim = gain_lane(REG_LIM_LO, i) & 64'h7FFF;
                if (mag != 0 && (!found || lim * worst_mag < worst_lim * mag))
                begin
                    found = 1'b1;
                    worst_lim = lim;
                    worst_mag = mag;
                end
            end
            scale = found && (worst_lim < worst_mag);
            periods_closed++;
            if (scale)
                periods_scaled++;
            for (int i = 0; i < JOINTS; i++)
            begin
                sum = longint'(torque_store[i]);
                if (scale)
                begin
                    mag = (sum < 0) ? -sum : sum;
                    quot = (mag * worst_lim) / worst_mag;
                    sum = (sum < 0) ? -quot : quot;
                end
                cmd.joint = i[2:0];
                cmd.torque = sum[15:0];
                cmd.scaled = scale;
                cmd.last = (i == JOINTS - 1);
                torque_queue = {torque_queue, cmd};
            end
        end
    endtask

    // Slave-side driver: predicts on each accepted transaction and offers the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin : drive
            logic taken;
            taken = s_axis_tvalid && s_axis_tready;
            if (taken)
                predict_torques(offered);
            if (!s_axis_tvalid || taken)
            begin
                if (sample_queue.size() > 0 && (steady || $urandom_range(99) >= 25))
                begin
                    offered = sample_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {offered.grav_torque, offered.ff_torque,
                                      offered.meas_vel, offered.ref_vel,
                                      offered.meas_pos, offered.ref_pos};
                    s_axis_tuser  <= offered.joint;
                    s_axis_tlast  <= offered.last_joint;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Master-side ready: random stalls, or a long hold-off when requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_count <= 0;
        end
        else if (hold_request && hold_count < HOLD_CYCLES)
        begin
            hold_count <= hold_count + 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= steady || ($urandom_range(99) >= 25);
    end

    // Monitor: compare each result transaction with the oldest expected torque.
    always @(posedge clk)
    begin : monitor
        drive_cmd_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (torque_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected torque joint=%0d torque=%0d",
                             m_axis_tuser[2:0], $signed(m_axis_tdata));
            end
            else
            begin
                want = torque_queue.pop_front();
                if (m_axis_tuser[2:0] !== want.joint || m_axis_tdata !== want.torque
                    || m_axis_tuser[3] !== want.scaled || m_axis_tlast !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: exp joint=%0d torque=%0d scaled=%0b last=%0b, got joint=%0d torque=%0d scaled=%0b last=%0b",
                                 want.joint, want.torque, want.scaled, want.last,
                                 m_axis_tuser[2:0], $signed(m_axis_tdata),
                                 m_axis_tuser[3], m_axis_tlast);
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
            $display("tb_joint_pd_feedforward_torque_limiter failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        reg_shadow[idx] = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic add_sample(input int j, input int rp, input int mp, input int rv,
                              input int mv, input int ff, input int gr, input bit last);
        joint_sample_t s;
        s.joint = j[2:0];
        s.ref_pos = rp[15:0];
        s.meas_pos = mp[15:0];
        s.ref_vel = rv[15:0];
        s.meas_vel = mv[15:0];
        s.ff_torque = ff[15:0];
        s.grav_torque = gr[15:0];
        s.last_joint = last;
        sample_queue = {sample_queue, s};
    endtask

    // Wait until every sample is sent and every torque has arrived, then let the block settle.
    task automatic drain();
        while (sample_queue.size() > 0 || s_axis_tvalid || torque_queue.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int rand_field();
        if ($urandom_range(1) == 1)
            return int'($urandom_range(65535)) - 32768;
        return int'($urandom_range(400)) - 200;
    endfunction

    function automatic logic [63:0] rand_reg();
        return {$urandom, $urandom} >> $urandom_range(48);
    endfunction

    task automatic add_random_samples(input int count);
        int n;
        int len;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(9) < 8)
            begin
                // A well-formed period: a few joints, the last one closes it.
                len = $urandom_range(JOINTS, 1);
                for (int k = 0; k < len; k++)
                    add_sample($urandom_range(JOINTS - 1), rand_field(), rand_field(),
                               rand_field(), rand_field(), rand_field(), rand_field(),
                               k == len - 1);
                n += len;
            end
            else
            begin
                add_sample($urandom_range(7), rand_field(), rand_field(), rand_field(),
                           rand_field(), rand_field(), rand_field(), $urandom_range(4) == 0);
                n++;
            end
        end
        // Close the phase so that nothing is left in flight.
        add_sample($urandom_range(7), rand_field(), rand_field(), rand_field(),
                   rand_field(), rand_field(), rand_field(), 1'b1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        steady = 1'b0;
        hold_request = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        periods_closed = 0;
        periods_scaled = 0;
        results_seen = 0;
        for (int i = 0; i < 6; i++)
            reg_shadow[i] = '0;
        for (int i = 0; i < 8; i++)
            torque_store[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Zero gains, full limits: every joint is written before the first close.
        write_reg(REG_KP_LO, 64'h0);
        write_reg(REG_KP_HI, 64'h0);
        write_reg(REG_KD_LO, 64'h0);
        write_reg(REG_KD_HI, 64'h0);
        write_reg(REG_LIM_LO, 64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(REG_LIM_HI, 64'h7FFF_7FFF_7FFF_7FFF);
        for (int j = 0; j < JOINTS; j++)
            add_sample(j, 0, 0, 0, 0, 100 * j, 0, j == JOINTS - 1);
        // Out-of-range joint still closes the period.
        add_sample(7, 32767, -32768, 32767, -32768, 32767, -32768, 1'b1);
        // Equal and opposite extremes on two joints: a tie, missing joints keep old torques.
        add_sample(2, 0, 0, 0, 0, 32767, -32768, 1'b0);
        add_sample(5, 0, 0, 0, 0, -32768, 32767, 1'b1);
        drain();

        // Full gains with one zero limit: the first closed vector collapses to zero.
        write_reg(REG_KP_LO, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_KP_HI, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_KD_LO, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_KD_HI, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_LIM_LO, 64'h7FFF_FFFF_0000_7FFF);
        write_reg(REG_LIM_HI, 64'h0001_7FFF_1234_FFFF);
        add_sample(0, 32767, -32768, 32767, -32768, 0, 0, 1'b0);
        add_sample(1, -32768, 32767, -32768, 32767, 0, 0, 1'b0);
        add_sample(3, 0, 0, 0, 0, 0, 0, 1'b1);
        add_sample(6, -32768, 32767, 5, -7, 1, 1, 1'b0);
        add_sample(1, 0, 0, 0, 0, 0, 0, 1'b1);
        drain();

        // Random settings, one at the maximum; one phase runs without idling and one
        // holds the receiver off so that the input stalls.
        for (int p = 0; p < 7; p++)
        begin
            for (int r = 0; r < 6; r++)
                write_reg(r[2:0], (p == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : rand_reg());
            steady = (p == 3);
            hold_request = (p == 5);
            add_random_samples(58);
            drain();
        end
        hold_request = 1'b0;
        steady = 1'b0;

        $display("Covered %0d closed periods (%0d scaled) and %0d torque results over",
                 periods_closed, periods_scaled, results_seen);
        $display("zero-gain, full-gain, zero-limit and random gain/limit settings.");
        if (mismatches == 0 && torque_queue.size() == 0)
            $display("tb_joint_pd_feedforward_torque_limiter passed");
        else
            $display("tb_joint_pd_feedforward_torque_limiter failed");
        $finish;
    end

endmodule
